[hdl/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg
// Shared widths, register indexes and controller/datapath handshake types
// for the selection sampling marker.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int COIN_W     = 32;
  localparam int CNT_W      = 32;
  localparam int SIDX_W     = 6;
  localparam int SMP_TOT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RECORD_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_TOTAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TOTAL = 2'd2;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
  } sts_t;

endpackage

[hdl/psm_if.sv]
// ----------------------------------------------------------------------------
// psm_if
// Valid/ready channels for the coin input and the decision output.
// ----------------------------------------------------------------------------
interface psm_in_if;
  logic                        valid;
  logic                        ready;
  logic [psm_pkg::COIN_W-1:0]  coin_value;

  modport source (output valid, output coin_value, input ready);
  modport sink   (input valid, input coin_value, output ready);
endinterface

interface psm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        mark_bit;
  logic [psm_pkg::CNT_W-1:0]   record_index;
  logic [psm_pkg::SIDX_W-1:0]  sample_index;
  logic                        end_of_record;
  logic                        end_of_pass;

  modport source (output valid, output mark_bit, output record_index, output sample_index,
                  output end_of_record, output end_of_pass, input ready);
  modport sink   (input valid, input mark_bit, input record_index, input sample_index,
                  input end_of_record, input end_of_pass, output ready);
endinterface

[hdl/psm_ram.sv]
// ----------------------------------------------------------------------------
// psm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/psm_ctrl.sv]
// ----------------------------------------------------------------------------
// psm_ctrl
// Sequencer: accept a coin, load operands, run the shift-add multiplier,
// then retire the decision into the output register.
// ----------------------------------------------------------------------------
module psm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  psm_pkg::sts_t sts,
  output psm_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_INIT)
    else $error("accepted coin did not move to operand load");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL && sts.mul_last |=> state_r == ST_DONE)
    else $error("multiplier end not followed by retire");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("retired decision not presented");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.init, cmd.step, cmd.finish}))
    else $error("more than one datapath command");
`endif

endmodule

[hdl/psm_dpath.sv]
// ----------------------------------------------------------------------------
// psm_dpath
// Configuration, position counters, picks-left memory, shift-add
// multiplier and the output register.
// ----------------------------------------------------------------------------
module psm_dpath #(
  parameter int MAX_SAMPLES = 64,
  parameter int COIN_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [psm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [psm_pkg::COIN_W-1:0]        in_coin,
  input  psm_pkg::cmd_t                     cmd,
  output psm_pkg::sts_t                     sts,
  output logic                              mark_bit,
  output logic [psm_pkg::CNT_W-1:0]         record_index,
  output logic [psm_pkg::SIDX_W-1:0]        sample_index,
  output logic                              end_of_record,
  output logic                              end_of_pass
);

  localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int KW = $clog2(MAX_SAMPLES + 1);
  localparam int NW = psm_pkg::CNT_W;
  localparam int PW = COIN_BITS + NW;
  localparam int CW = $clog2(COIN_BITS);

  logic [NW-1:0]                  rec_tot_r;
  logic [NW-1:0]                  pick_tot_r;
  logic [psm_pkg::SMP_TOT_W-1:0]  smp_tot_r;

  logic [NW-1:0]        rec_r;
  logic [NW-1:0]        rec_nxt;
  logic [SW-1:0]        smp_r;
  logic [SW-1:0]        smp_nxt;

  logic [COIN_BITS-1:0] cbits_r;
  logic [NW-1:0]        left_r;
  logic [PW-1:0]        acc_r;
  logic [PW-1:0]        msh_r;
  logic [CW-1:0]        bcnt_r;

  logic                 mark_r;
  logic [NW-1:0]        orec_r;
  logic [psm_pkg::SIDX_W-1:0] osmp_r;
  logic                 eor_r;
  logic                 eop_r;

  logic [NW-1:0]        n_eff;
  logic [NW-1:0]        m_eff;
  logic [KW-1:0]        k_eff;
  logic [NW-1:0]        remaining;
  logic [NW-1:0]        ram_rdata;
  logic [NW-1:0]        left_dec;
  logic                 mark;
  logic                 last_smp;
  logic                 last_rec;
  logic                 cfg_hit;

  // effective register values
  always_comb begin
    n_eff = (rec_tot_r == '0) ? NW'(1) : rec_tot_r;
    m_eff = (pick_tot_r > n_eff) ? n_eff : pick_tot_r;
    if (smp_tot_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(smp_tot_r) > 32'(MAX_SAMPLES)) begin
      k_eff = KW'(MAX_SAMPLES);
    end else begin
      k_eff = KW'(smp_tot_r);
    end
  end

  assign remaining = n_eff - rec_r;
  assign last_smp  = (KW'(smp_r) + KW'(1)) == k_eff;
  assign last_rec  = (rec_r + NW'(1)) == n_eff;
  assign mark      = acc_r <= {left_r, {COIN_BITS{1'b0}}};
  assign left_dec  = left_r - NW'(mark);
  assign sts.mul_last = (bcnt_r == CW'(COIN_BITS - 1));

  always_comb begin
    rec_nxt = rec_r;
    smp_nxt = smp_r;
    if (last_smp) begin
      smp_nxt = '0;
      rec_nxt = last_rec ? '0 : rec_r + NW'(1);
    end else begin
      smp_nxt = smp_r + SW'(1);
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        psm_pkg::REG_RECORD_TOTAL: cfg_hit = 1'b1;
        psm_pkg::REG_PICK_TOTAL:   cfg_hit = 1'b1;
        psm_pkg::REG_SAMPLE_TOTAL: cfg_hit = 1'b1;
        default:                   cfg_hit = 1'b0;
      endcase
    end
  end

  // config registers and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_tot_r  <= NW'(1);
      pick_tot_r <= NW'(1);
      smp_tot_r  <= psm_pkg::SMP_TOT_W'(1);
      rec_r      <= '0;
      smp_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psm_pkg::REG_RECORD_TOTAL: rec_tot_r  <= cfg_data[NW-1:0];
          psm_pkg::REG_PICK_TOTAL:   pick_tot_r <= cfg_data[NW-1:0];
          psm_pkg::REG_SAMPLE_TOTAL: smp_tot_r  <= cfg_data[psm_pkg::SMP_TOT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        rec_r <= '0;
        smp_r <= '0;
      end else if (cmd.finish) begin
        rec_r <= rec_nxt;
        smp_r <= smp_nxt;
      end
    end
  end

  // picks left per sample; record 0 always takes the reload value
  psm_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_SAMPLES)
  ) u_left_ram (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (smp_r),
    .wdata (left_dec),
    .re    (cmd.load),
    .raddr (smp_r),
    .rdata (ram_rdata)
  );

  // shift-add multiplier: acc = remaining * (coin + 1)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cbits_r <= in_coin[COIN_BITS-1:0];
    end
    if (cmd.init) begin
      left_r <= (rec_r == '0) ? m_eff : ram_rdata;
      acc_r  <= PW'(remaining);
      msh_r  <= PW'(remaining);
      bcnt_r <= '0;
    end else if (cmd.step) begin
      if (cbits_r[0]) begin
        acc_r <= acc_r + msh_r;
      end
      msh_r   <= {msh_r[PW-2:0], 1'b0};
      cbits_r <= {1'b0, cbits_r[COIN_BITS-1:1]};
      bcnt_r  <= bcnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mark_r <= mark;
      orec_r <= rec_r;
      osmp_r <= psm_pkg::SIDX_W'(smp_r);
      eor_r  <= last_smp;
      eop_r  <= last_smp && last_rec;
    end
  end

  assign mark_bit      = mark_r;
  assign record_index  = orec_r;
  assign sample_index  = osmp_r;
  assign end_of_record = eor_r;
  assign end_of_pass   = eop_r;

endmodule

[hdl/parallel_selection_sampling_marker_unit.sv]
// ----------------------------------------------------------------------------
// parallel_selection_sampling_marker_unit
// Selection sampling marker: one mark decision per random coin, for
// several independent samples drawn side by side.
// ----------------------------------------------------------------------------
// Each coin runs through these steps in order: accept the beat and read the
// sample's picks-left word from memory, load the operands, run the shift-add
// multiplier over the coin bits to form (coin + 1) * remaining, then compare
// against picks_left * 2^bits, write the count back and load the output
// register. The output register holds a decision until it is taken, while
// the next coin is already accepted. No clearing pass is needed after reset
// or a register write: the first record of a pass takes the reloaded count.
module parallel_selection_sampling_marker_unit #(
  parameter int MAX_SAMPLES = 64,
  parameter int COIN_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  psm_in_if.sink                          in_ch,
  psm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [psm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  psm_pkg::cmd_t cmd;
  psm_pkg::sts_t sts;

  psm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  psm_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .COIN_BITS   (COIN_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_coin       (in_ch.coin_value),
    .cmd           (cmd),
    .sts           (sts),
    .mark_bit      (out_ch.mark_bit),
    .record_index  (out_ch.record_index),
    .sample_index  (out_ch.sample_index),
    .end_of_record (out_ch.end_of_record),
    .end_of_pass   (out_ch.end_of_pass)
  );

endmodule
